### hdl/mlbhd_pkg.sv
// Shared constants, types and hash step functions for the multi-lane byte hash digest.
package mlbhd_pkg;

    // Lane count limits
    localparam int LANES_DEF = 16;
    localparam int MAX_LANES = 16;

    // Hash constants; the FNV prime is 2^40 + 0x1B3
    localparam logic [31:0] MUR_MUL         = 32'h5bd1e995;
    localparam logic [63:0] FNV_BASIS       = 64'hcbf29ce484222325;
    localparam logic [8:0]  FNV_PRIME_LO    = 9'h1B3;
    localparam int          FNV_PRIME_SHIFT = 40;

    // Digest mode codes; codes above MODE_L16 behave as MODE_L16
    localparam logic [2:0] MODE_MURMUR = 3'd0;
    localparam logic [2:0] MODE_FNV    = 3'd1;
    localparam logic [2:0] MODE_L2     = 3'd2;
    localparam logic [2:0] MODE_L4     = 3'd3;
    localparam logic [2:0] MODE_L8     = 3'd4;
    localparam logic [2:0] MODE_L16    = 3'd5;
    localparam logic [2:0] MODE_RESET  = MODE_L16;

    // Byte position of the final FNV step over a 32-bit lane word
    localparam logic [1:0] STEP_LAST = 2'd3;

    typedef enum logic {
        ST_IDLE,
        ST_FIN
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       absorb;
        logic       restart;
        logic       fin_step;
        logic       load;
        logic [1:0] step;
        logic [3:0] idx;
        logic       last_word;
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [2:0] mode;
    } dp_status_t;

    // Fixed per-lane seeds
    function automatic logic [31:0] lane_seed(input logic [3:0] i);
        logic [31:0] s;
        case (i)
            4'd0:    s = 32'h12345678;
            4'd1:    s = 32'h23456789;
            4'd2:    s = 32'h34567890;
            4'd3:    s = 32'h45678901;
            4'd4:    s = 32'h56789012;
            4'd5:    s = 32'h67890123;
            4'd6:    s = 32'h78901234;
            4'd7:    s = 32'h89012345;
            4'd8:    s = 32'h90123456;
            4'd9:    s = 32'h01234567;
            4'd10:   s = 32'h11234567;
            4'd11:   s = 32'h22345678;
            4'd12:   s = 32'h33456789;
            4'd13:   s = 32'h44567890;
            4'd14:   s = 32'h55678901;
            default: s = 32'h66789012;
        endcase
        return s;
    endfunction

    // One Murmur one-at-a-time byte step, mod 2^32
    function automatic logic [31:0] mur_step(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] x;
        logic [31:0] p;
        x = h ^ {24'd0, b};
        p = x * MUR_MUL;
        return p ^ (p >> 15);
    endfunction

    // One FNV-1a 64 byte step; multiply by the prime as a shift plus a narrow product
    function automatic logic [63:0] fnv_step(input logic [63:0] f, input logic [7:0] b);
        logic [63:0] x;
        x = f ^ {56'd0, b};
        return (x << FNV_PRIME_SHIFT) + (x * {55'd0, FNV_PRIME_LO});
    endfunction

endpackage

### hdl/mlbhd_ctrl.sv
// Controller for the byte hash digest: message intake, finalisation sequencing, output flag.
module mlbhd_ctrl #(
    parameter int LANES = mlbhd_pkg::LANES_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   has_byte,
    input  logic                   last_byte,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  mlbhd_pkg::dp_status_t  status,
    output mlbhd_pkg::ctrl_cmd_t   cmd
);
    import mlbhd_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] step_reg, step_next;
    logic [3:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic       multi;
    logic       out_free;
    logic [3:0] words_last;
    logic [3:0] last_idx;

    // Digest shape from the mode
    always_comb
    begin
        multi = !(status.mode inside {MODE_MURMUR, MODE_FNV});
        case (status.mode)
            MODE_L2: words_last = 4'd1;
            MODE_L4: words_last = 4'd3;
            MODE_L8: words_last = 4'd7;
            default: words_last = 4'd15;
        endcase
        if (words_last > 4'(LANES - 1))
            last_idx = 4'(LANES - 1);
        else
            last_idx = words_last;
    end

    // Output register can take a new word
    assign out_free = !out_valid_reg || out_ready;

    // Outputs and commands
    always_comb
    begin
        in_ready      = (state_reg == ST_IDLE);
        cmd.absorb    = 1'b0;
        cmd.restart   = 1'b0;
        cmd.fin_step  = 1'b0;
        cmd.load      = 1'b0;
        cmd.step      = step_reg;
        cmd.idx       = idx_reg;
        cmd.last_word = multi ? (idx_reg == last_idx) : 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.absorb = in_valid && has_byte;
            end
            ST_FIN:
            begin
                if (multi)
                begin
                    cmd.fin_step = (step_reg != STEP_LAST);
                    cmd.load     = (step_reg == STEP_LAST) && out_free;
                end
                else
                begin
                    cmd.load = out_free;
                end
                cmd.restart = cmd.load && cmd.last_word;
            end
            default:
            begin
                cmd.absorb = 1'b0;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && last_byte)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (cmd.restart)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Step and lane counters, output valid flag
    always_comb
    begin
        step_next = step_reg;
        idx_next  = idx_reg;
        if (cmd.fin_step)
            step_next = step_reg + 2'd1;
        else if (cmd.load)
            step_next = 2'd0;
        if (cmd.load)
            idx_next = cmd.restart ? 4'd0 : idx_reg + 4'd1;
        out_valid_next = cmd.load || (out_valid_reg && !out_ready);
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= 2'd0;
            idx_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### hdl/mlbhd_dp.sv
// Datapath for the byte hash digest: Murmur lanes, FNV state, finalisation unit, output word.
module mlbhd_dp #(
    parameter int LANES = mlbhd_pkg::LANES_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [7:0]             data_byte,
    input  logic                   cfg_valid,
    input  logic [2:0]             digest_mode,
    input  mlbhd_pkg::ctrl_cmd_t   cmd,
    output mlbhd_pkg::dp_status_t  status,
    output logic [63:0]            digest_word,
    output logic [3:0]             word_index,
    output logic                   last_word
);
    import mlbhd_pkg::*;

    localparam int LW = $clog2(LANES);

    logic [31:0] lane_reg [LANES];
    logic [31:0] lane_next [LANES];
    logic [63:0] byte_fnv_reg, byte_fnv_next;
    logic [2:0]  mode_reg;
    logic [63:0] acc_reg;
    logic [63:0] acc_in, acc_next;
    logic [31:0] lane_sel;
    logic [7:0]  byte_sel;
    logic [63:0] digest_reg, digest_next;
    logic [3:0]  index_reg;
    logic        last_reg;

    // Murmur lanes: one multiplier each, all step on every byte
    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        always_comb
        begin
            if (cmd.restart)
                lane_next[i] = lane_seed(4'(i));
            else if (cmd.absorb)
                lane_next[i] = mur_step(lane_reg[i], data_byte);
            else
                lane_next[i] = lane_reg[i];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                lane_reg[i] <= lane_seed(4'(i));
            else
                lane_reg[i] <= lane_next[i];
        end
    end

    // Running FNV-1a 64 over the message bytes
    always_comb
    begin
        if (cmd.restart)
            byte_fnv_next = FNV_BASIS;
        else if (cmd.absorb)
            byte_fnv_next = fnv_step(byte_fnv_reg, data_byte);
        else
            byte_fnv_next = byte_fnv_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_fnv_reg <= FNV_BASIS;
            mode_reg     <= MODE_RESET;
        end
        else
        begin
            byte_fnv_reg <= byte_fnv_next;
            if (cfg_valid)
                mode_reg <= digest_mode;
        end
    end

    assign status.mode = mode_reg;

    // Finalise selected lane word little-endian: one FNV byte step per cycle unless stalled
    always_comb
    begin
        lane_sel = lane_reg[cmd.idx[LW-1:0]];
        byte_sel = lane_sel[{cmd.step, 3'b000} +: 8];
        acc_in   = (cmd.step == 2'd0) ? FNV_BASIS : acc_reg;
        acc_next = fnv_step(acc_in, byte_sel);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin_step)
            acc_reg <= acc_next;
    end

    // Output word select
    always_comb
    begin
        case (mode_reg)
            MODE_MURMUR: digest_next = {32'd0, lane_reg[0]};
            MODE_FNV:    digest_next = byte_fnv_reg;
            default:     digest_next = acc_next;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            digest_reg <= digest_next;
            index_reg  <= cmd.idx;
            last_reg   <= cmd.last_word;
        end
    end

    assign digest_word = digest_reg;
    assign word_index  = index_reg;
    assign last_word   = last_reg;

endmodule

### hdl/multi_lane_byte_hash_digest.sv
// Multi-lane byte hash digest: top level joining controller and datapath.
//
// Usage: message bytes enter on the in channel (data_byte, has_byte, last_byte),
// one word per cycle while the block is taking a message. Every byte steps all
// Murmur lanes and the running FNV-1a 64 in that cycle. An item with last_byte
// set closes the message; has_byte low with last_byte high closes an empty one.
// Digest words leave on the out channel with word_index and last_word.
// digest_mode is to be written on the cfg channel while idle; the block has
// no check for this, and cfg_ready is always high. After the closing word,
// modes 0 and 1 give their single word; lane modes spend four FNV byte steps
// per digest word, one step a cycle in the shared finalisation unit, and no
// message byte is taken meanwhile.
// The output word sits in a register; the next word is computed while it waits,
// and a new message may start while the final word still waits.
// A stalled receiver holds the finalisation at its last byte step.
// Reset: lanes return to their seeds, FNV to its offset basis, mode to 5,
// and no word is pending.
module multi_lane_byte_hash_digest #(
    parameter int LANES = mlbhd_pkg::LANES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] digest_word,
    output logic [3:0]  word_index,
    output logic        last_word,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  digest_mode
);
    import mlbhd_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    // Sequencer
    mlbhd_ctrl #(
        .LANES (LANES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .has_byte  (has_byte),
        .last_byte (last_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Hash state and output register
    mlbhd_dp #(
        .LANES (LANES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_byte   (data_byte),
        .cfg_valid   (cfg_valid),
        .digest_mode (digest_mode),
        .cmd         (cmd),
        .status      (status),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

`ifndef SYNTHESIS
    // A new word only enters the output register when the old one is gone
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!out_valid || out_ready))
        else $error("output word overwritten while pending");

    // No message byte is taken during finalisation
    a_fin_no_in: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.fin_step || cmd.load) |-> !in_ready)
        else $error("input accepted during finalisation");

    // Hash state returns to seeds only together with the final digest word
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.restart |-> (cmd.load && cmd.last_word))
        else $error("restart without final word");
`endif

endmodule
